// File: sv/mbq_pkg.sv
package mbq_pkg;

  localparam int CHANNELS_DEF    = 32;
  localparam int SECTIONS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TERMS           = 6;
  localparam int COEF_W          = 24;
  localparam int CH_W            = 5;
  localparam int IDX_W           = 5;
  localparam int NS_W            = 3;
  localparam int SAMPLE_W        = SAMPLE_BITS_DEF;

  // Request kinds on the input channel.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Coefficient term codes within one section.
  localparam logic [2:0] TERM_B0   = 3'd0;
  localparam logic [2:0] TERM_B1   = 3'd1;
  localparam logic [2:0] TERM_B2   = 3'd2;
  localparam logic [2:0] TERM_A1   = 3'd3;
  localparam logic [2:0] TERM_A2   = 3'd4;
  localparam logic [2:0] TERM_GAIN = 3'd5;

  // Token handed from cell to cell along the cascade.
  typedef struct packed {
    logic                       valid;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] x;
    logic                       clip;
    logic [NS_W:0]              left;
  } tok_t;

  // Coefficient write broadcast to the cells.
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] value;
  } cwr_t;

endpackage

// File: sv/mbq_if.sv
interface mbq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic [mbq_pkg::CH_W-1:0]               channel;
  logic signed [mbq_pkg::SAMPLE_W-1:0]    sample_in;
  logic [mbq_pkg::IDX_W-1:0]              coef_index;
  logic signed [mbq_pkg::COEF_W-1:0]      coef_value;
  modport source (output valid, req_type, channel, sample_in, coef_index, coef_value,
                  input ready);
  modport sink (input valid, req_type, channel, sample_in, coef_index, coef_value,
                output ready);
endinterface

interface mbq_out_if;
  logic                                valid;
  logic                                ready;
  logic [mbq_pkg::CH_W-1:0]            out_channel;
  logic signed [mbq_pkg::SAMPLE_W-1:0] sample_out;
  logic                                clipped;
  modport source (output valid, out_channel, sample_out, clipped, input ready);
  modport sink (input valid, out_channel, sample_out, clipped, output ready);
endinterface

interface mbq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mbq_pkg::NS_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/multichannel_biquad_cascade.sv
// A sample beat runs through each active cell in turn (history read, numerator products,
// gain, feedback products, output), then is handed through each later cell and registered
// to the output. Only one beat is in flight at a time: no new beat, sample or coefficient
// write, is taken until the result beat is taken. Each section cell runs one shared
// multiplier over six products. Synchronous reset clears coefficients, history valid bits
// and sets num_sections to 1.
module multichannel_biquad_cascade #(
  parameter int CHANNELS    = mbq_pkg::CHANNELS_DEF,
  parameter int SECTIONS    = mbq_pkg::SECTIONS_DEF
) (
  input logic clk,
  input logic rst,
  mbq_in_if.sink    in_ch,
  mbq_out_if.source out_ch,
  mbq_cfg_if.sink   cfg
);

  localparam int NW = mbq_pkg::NS_W;

  logic [NW-1:0] num_sections;
  logic busy;
  logic [NW:0] ns_eff;
  mbq_pkg::tok_t chain [SECTIONS+1];
  mbq_pkg::cwr_t cwr;
  logic out_valid;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) num_sections <= NW'(1);
    else if (cfg.valid) num_sections <= cfg.data;
  end

  // Clamp the section count to 1..SECTIONS.
  always_comb begin
    ns_eff = {1'b0, num_sections};
    if (num_sections == '0) ns_eff = (NW+1)'(1);
    else if (int'(num_sections) > SECTIONS) ns_eff = (NW+1)'(SECTIONS);
  end

  // Launch a token or broadcast a coefficient write.
  always_comb begin
    cwr.we = in_ch.valid && in_ch.ready && (in_ch.req_type == mbq_pkg::REQ_COEF)
             && (int'(in_ch.coef_index) < SECTIONS * mbq_pkg::TERMS);
    cwr.idx = in_ch.coef_index;
    cwr.value = in_ch.coef_value;
    chain[0].valid = in_ch.valid && in_ch.ready && (in_ch.req_type == mbq_pkg::REQ_SAMPLE)
                     && (int'(in_ch.channel) < CHANNELS);
    chain[0].channel = in_ch.channel;
    chain[0].x = in_ch.sample_in;
    chain[0].clip = 1'b0;
    chain[0].left = ns_eff;
  end

  for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
    mbq_cell #(.CHANNELS(CHANNELS), .SECTION(s)) u_cell (
      .clk, .rst, .cwr, .tok_in(chain[s]), .tok_out(chain[s+1]));
  end

  // Busy from sample launch until the result beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (chain[0].valid) busy <= 1'b1;
      if (chain[SECTIONS].valid) begin
        out_valid <= 1'b1;
        out_ch.out_channel <= chain[SECTIONS].channel;
        out_ch.sample_out <= chain[SECTIONS].x;
        out_ch.clipped <= chain[SECTIONS].clip;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end
    end
  end
  assign out_ch.valid = out_valid;

  ast_out_only_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result while idle");
  ast_no_launch_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !chain[0].valid) else $error("launch while busy");
  ast_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.ready) |=> !busy) else $error("busy stuck");

endmodule

// File: sv/mbq_cell.sv
module mbq_cell #(
  parameter int CHANNELS    = mbq_pkg::CHANNELS_DEF,
  parameter int SECTION     = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  mbq_pkg::cwr_t cwr,
  input  mbq_pkg::tok_t tok_in,
  output mbq_pkg::tok_t tok_out
);

  localparam int CA_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW   = mbq_pkg::SAMPLE_W;
  localparam int CW   = mbq_pkg::COEF_W;
  localparam logic signed [63:0] HI = (64'sd1 <<< (mbq_pkg::SAMPLE_BITS_DEF-1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001, ST_RD  = 6'b000010, ST_MAC = 6'b000100,
    ST_GAIN = 6'b001000, ST_FB  = 6'b010000, ST_OUT = 6'b100000
  } st_t;

  // This section's six coefficient words.
  logic signed [CW-1:0] coef [mbq_pkg::TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mbq_pkg::TERMS; i++) coef[i] <= '0;
    end else if (cwr.we) begin
      for (int i = 0; i < mbq_pkg::TERMS; i++)
        if (int'(cwr.idx) == SECTION * mbq_pkg::TERMS + i) coef[i] <= cwr.value;
    end
  end

  // Per-channel history (x1, x2, y1, y2) packed in one word; per-channel valid bits stand in for reset.
  logic [4*SW-1:0] hist_mem [CHANNELS];
  logic [CHANNELS-1:0] hvalid;
  logic [4*SW-1:0] hist_rd;
  logic            hist_ok;
  logic [CA_W-1:0] ch_idx;

  st_t  state;
  mbq_pkg::tok_t cur;
  logic [2:0] step;
  logic signed [63:0] acc, n;
  logic signed [63:0] prod;
  logic signed [CW-1:0] mc;
  logic signed [31:0] md;
  logic signed [CW+31:0] mul;
  logic signed [SW-1:0] x1, x2, y1, y2;
  logic signed [63:0] r;
  logic signed [SW-1:0] rsat;
  logic rclip;

  assign ch_idx = CA_W'(cur.channel);

  assign x1 = hist_ok ? hist_rd[SW-1:0]      : '0;
  assign x2 = hist_ok ? hist_rd[2*SW-1:SW]   : '0;
  assign y1 = hist_ok ? hist_rd[3*SW-1:2*SW] : '0;
  assign y2 = hist_ok ? hist_rd[4*SW-1:3*SW] : '0;

  // One shared multiplier: operands chosen by step. The numerator after the
  // shift by 9 always fits 32 signed bits, so a 24 by 32 product suffices.
  always_comb begin
    mc = coef[0];
    md = 32'(cur.x);
    unique case (step)
      3'd0: begin mc = coef[mbq_pkg::TERM_B0]; md = 32'(cur.x); end
      3'd1: begin mc = coef[mbq_pkg::TERM_B1]; md = 32'(x1); end
      3'd2: begin mc = coef[mbq_pkg::TERM_B2]; md = 32'(x2); end
      3'd3: begin mc = coef[mbq_pkg::TERM_GAIN]; md = n[31:0]; end
      3'd4: begin mc = coef[mbq_pkg::TERM_A1]; md = 32'(y1); end
      3'd5: begin mc = coef[mbq_pkg::TERM_A2]; md = 32'(y2); end
      default: begin mc = coef[0]; md = 32'(cur.x); end
    endcase
  end

  assign mul = mc * md;

  // Rounding and saturation of the finished sum.
  always_comb begin
    r = (acc + (64'sd1 <<< 32)) >>> 33;
    rclip = 1'b0;
    rsat = r[SW-1:0];
    if (r > HI) begin rsat = HI[SW-1:0]; rclip = 1'b1; end
    else if (r < LO) begin rsat = LO[SW-1:0]; rclip = 1'b1; end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      hist_rd <= hist_mem[ch_idx];
      hist_ok <= hvalid[ch_idx];
    end
    if (state == ST_OUT)
      hist_mem[ch_idx] <= {y1, rsat, x1, cur.x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hvalid <= '0;
      tok_out <= '0;
      step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (tok_in.valid && tok_in.left == '0) begin
            tok_out <= tok_in;
          end else begin
            tok_out.valid <= 1'b0;
            if (tok_in.valid) begin cur <= tok_in; state <= ST_RD; end
          end
        end
        ST_RD: begin
          tok_out.valid <= 1'b0;
          step <= 3'd0;
          acc <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          tok_out.valid <= 1'b0;
          prod <= 64'(mul);
          if (step != 3'd0) acc <= acc + prod;
          if (step == 3'd2) state <= ST_GAIN;
          step <= step + 3'd1;
        end
        ST_GAIN: begin
          // Last numerator product lands; form the Q.12 value.
          tok_out.valid <= 1'b0;
          n <= (acc + prod) >>> 9;
          step <= 3'd3;
          state <= ST_FB;
          acc <= '0;
        end
        ST_FB: begin
          tok_out.valid <= 1'b0;
          prod <= 64'(mul);
          if (step == 3'd4) acc <= prod;
          else if (step != 3'd3) acc <= acc - (prod <<< 12);
          if (step == 3'd6) state <= ST_OUT;
          step <= step + 3'd1;
        end
        ST_OUT: begin
          hvalid[ch_idx] <= 1'b1;
          tok_out.valid <= 1'b1;
          tok_out.channel <= cur.channel;
          tok_out.x <= rsat;
          tok_out.clip <= cur.clip | rclip;
          tok_out.left <= cur.left - 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          tok_out.valid <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  ast_busy_no_token: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !tok_in.valid) else $error("token into busy cell");
  ast_out_pulse: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid |=> !tok_out.valid) else $error("token held two cycles");
  ast_out_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> tok_out.valid) else $error("finished token lost");

endmodule
